FILE: rtl/swdm_pkg.sv
// Shared constants for the sliding window distinct maximum block.
package swdm_pkg;

  localparam int ID_BITS_DEF    = 8;
  localparam int WINDOW_MAX_DEF = 256;
  localparam int WL_BITS        = 9;
  localparam int OUT_BITS       = 9;
  localparam int EPOCH_BITS     = 8;
  localparam int DATA_PAD_BITS  = 16;

endpackage

FILE: rtl/swdm_cnt_mem.sv
// Count table memory: one write port, two registered read ports.
module swdm_cnt_mem #(
  parameter int ADDR_BITS = swdm_pkg::ID_BITS_DEF,
  parameter int DATA_BITS = swdm_pkg::EPOCH_BITS + swdm_pkg::WL_BITS
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [DATA_BITS-1:0] rdata_a,
  output logic [DATA_BITS-1:0] rdata_b
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: rtl/swdm_ring_mem.sv
// Window ring memory: read and write at one address in the same cycle.
module swdm_ring_mem #(
  parameter int ADDR_BITS = 8,
  parameter int DEPTH     = swdm_pkg::WINDOW_MAX_DEF,
  parameter int DATA_BITS = swdm_pkg::ID_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [DATA_BITS-1:0] wdata,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Hand back the identifier that leaves while the new one is stored.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

FILE: rtl/sliding_window_distinct_max.sv
// Sliding window distinct maximum: top level with the three stage pipeline.
//
// Takes one identifier word per cycle while s_tready is high and, on the word marked
// by s_tlast, gives one result word: the largest number of distinct identifiers seen
// in any full window of window_len consecutive words (tdata), and a flag set when no
// full window existed (tuser). Sustained rate is one word per cycle when nothing
// stalls; the pipeline is ring read, count read, count update, after which a result
// waits in an output register while new words keep flowing. Occurrence counts
// live in two memories (insertions and removals per identifier) tagged with a
// sequence epoch, so ending a sequence or writing window_len clears them at once.
// After reset, and after every 2**EPOCH_BITS - 1 ended sequences or window_len
// writes, a clearing pass over all 2**ID_BITS entries (256 by default) runs, during
// which no word is taken; writes to window_len are taken at any time but belong only
// where the block is idle.
module sliding_window_distinct_max #(
  parameter int ID_BITS    = swdm_pkg::ID_BITS_DEF,
  parameter int WINDOW_MAX = swdm_pkg::WINDOW_MAX_DEF,
  parameter int IN_BITS    = ((ID_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swdm_pkg::WL_BITS-1:0] cfg_data,       // window_len
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_BITS-1:0]           s_tdata,        // item_id, zero fill
  input  logic                         s_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [swdm_pkg::DATA_PAD_BITS-1:0] m_tdata,  // max_distinct, zero fill
  output logic [0:0]                   m_tuser         // no_full_window
);
  import swdm_pkg::*;

  localparam int CB   = $clog2(WINDOW_MAX + 1);
  localparam int DW   = $clog2(WINDOW_MAX + 2);
  localparam int CMPW = (CB > WL_BITS) ? CB : WL_BITS;
  localparam int RA   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int EW   = EPOCH_BITS + CB;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};

  logic [WL_BITS-1:0]    window_len;
  logic                  usable;
  logic                  cfg_we;
  logic                  accept;
  logic                  adv;

  logic [RA-1:0]         ring_pos;
  logic [CB-1:0]         items_seen;
  logic [ID_BITS-1:0]    id_in;
  logic                  full0_in;
  logic                  full1_in;
  logic [CMPW-1:0]       seen_inc;
  logic [CMPW-1:0]       pos_inc;
  logic [ID_BITS-1:0]    ring_rdata;

  logic                  s1_valid, s1_last, s1_use, s1_full0, s1_full1;
  logic [ID_BITS-1:0]    s1_id;
  logic                  s2_valid, s2_last, s2_use, s2_full0, s2_full1;
  logic [ID_BITS-1:0]    s2_id, s2_old;

  logic [EW-1:0]         ins_rd_a, ins_rd_b, rem_rd_a, rem_rd_b;
  logic [EW-1:0]         ins_id_e, ins_old_e, rem_id_e, rem_old_e;
  logic [CB-1:0]         ins_id_c, ins_old_c, rem_id_c, rem_old_c;
  logic [CB-1:0]         occ_id, occ_old, occ_old_new;

  logic                  fi_valid, fr_valid;
  logic [ID_BITS-1:0]    fi_addr, fr_addr;
  logic [EW-1:0]         fi_data, fr_data;

  logic                  work, swap, same, do_inc, do_dec, d_in, d_out;
  logic [DW-1:0]         distinct_now, best_distinct, dist_mid, dist_new, best_new;
  logic                  res_ok;

  logic                  ins_we, rem_we;
  logic [ID_BITS-1:0]    ins_waddr, rem_waddr;
  logic [EW-1:0]         ins_wdata, rem_wdata;

  logic                  sweeping;
  logic [ID_BITS-1:0]    sweep_cnt;
  logic [EPOCH_BITS-1:0] epoch;
  logic                  bump;
  logic                  wrap_hold;

  // Configuration register
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign usable    = (window_len != '0) && (int'(window_len) <= WINDOW_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WL_BITS'(1);
    end else if (cfg_we) begin
      window_len <= cfg_data;
    end
  end

  // Handshake: stall only when a second result would meet a full output register
  assign adv       = !(s2_valid && s2_last && m_tvalid && !m_tready);
  assign wrap_hold = (epoch == EPOCH_LAST) && ((s1_valid && s1_last) || (s2_valid && s2_last));
  assign s_tready  = adv && !sweeping && !wrap_hold;
  assign accept    = s_tvalid && s_tready;

  // Accept stage: window position and fill level
  assign id_in    = s_tdata[ID_BITS-1:0];
  assign full0_in = CMPW'(items_seen) >= CMPW'(window_len);
  assign seen_inc = CMPW'(items_seen) + CMPW'(1);
  assign full1_in = full0_in || (seen_inc >= CMPW'(window_len));
  assign pos_inc  = CMPW'(ring_pos) + CMPW'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      ring_pos   <= '0;
      items_seen <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        ring_pos   <= '0;
        items_seen <= '0;
      end else if (usable) begin
        ring_pos <= (pos_inc >= CMPW'(window_len)) ? '0 : pos_inc[RA-1:0];
        if (!full0_in) begin
          items_seen <= seen_inc[CB-1:0];
        end
      end
    end
  end

  swdm_ring_mem #(
    .ADDR_BITS(RA),
    .DEPTH    (WINDOW_MAX),
    .DATA_BITS(ID_BITS)
  ) u_ring (
    .clk  (clk),
    .en   (accept && usable),
    .addr (ring_pos),
    .wdata(id_in),
    .rdata(ring_rdata)
  );

  // Pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        s1_id    <= id_in;
        s1_last  <= s_tlast;
        s1_use   <= usable;
        s1_full0 <= full0_in;
        s1_full1 <= full1_in;
      end
      s2_id    <= s1_id;
      s2_old   <= ring_rdata;
      s2_last  <= s1_last;
      s2_use   <= s1_use;
      s2_full0 <= s1_full0;
      s2_full1 <= s1_full1;
    end
  end

  swdm_cnt_mem #(
    .ADDR_BITS(ID_BITS),
    .DATA_BITS(EW)
  ) u_ins (
    .clk    (clk),
    .we     (ins_we),
    .waddr  (ins_waddr),
    .wdata  (ins_wdata),
    .re     (adv && s1_valid),
    .raddr_a(s1_id),
    .raddr_b(ring_rdata),
    .rdata_a(ins_rd_a),
    .rdata_b(ins_rd_b)
  );

  swdm_cnt_mem #(
    .ADDR_BITS(ID_BITS),
    .DATA_BITS(EW)
  ) u_rem (
    .clk    (clk),
    .we     (rem_we),
    .waddr  (rem_waddr),
    .wdata  (rem_wdata),
    .re     (adv && s1_valid),
    .raddr_a(s1_id),
    .raddr_b(ring_rdata),
    .rdata_a(rem_rd_a),
    .rdata_b(rem_rd_b)
  );

  // Update stage: forward the write of the previous edge, drop stale epochs
  always_comb begin
    ins_id_e  = (fi_valid && fi_addr == s2_id)  ? fi_data : ins_rd_a;
    ins_old_e = (fi_valid && fi_addr == s2_old) ? fi_data : ins_rd_b;
    rem_id_e  = (fr_valid && fr_addr == s2_id)  ? fr_data : rem_rd_a;
    rem_old_e = (fr_valid && fr_addr == s2_old) ? fr_data : rem_rd_b;

    ins_id_c  = (ins_id_e[EW-1 -: EPOCH_BITS]  == epoch) ? ins_id_e[CB-1:0]  : '0;
    ins_old_c = (ins_old_e[EW-1 -: EPOCH_BITS] == epoch) ? ins_old_e[CB-1:0] : '0;
    rem_id_c  = (rem_id_e[EW-1 -: EPOCH_BITS]  == epoch) ? rem_id_e[CB-1:0]  : '0;
    rem_old_c = (rem_old_e[EW-1 -: EPOCH_BITS] == epoch) ? rem_old_e[CB-1:0] : '0;

    occ_id  = ins_id_c - rem_id_c;
    occ_old = ins_old_c - rem_old_c;

    work   = adv && s2_valid && s2_use;
    swap   = s2_full0;
    same   = (s2_old == s2_id);
    do_inc = work && !(swap && same);
    do_dec = work && swap && !same && (occ_old != '0);
    d_in   = do_inc && (occ_id == '0);

    occ_old_new = occ_old - CB'(do_dec);
    dist_mid    = distinct_now + DW'(d_in);
    d_out       = work && swap && !same && (occ_old_new == '0) && (dist_mid != '0);
    dist_new    = dist_mid - DW'(d_out);
    best_new    = (work && s2_full1 && dist_new > best_distinct) ? dist_new : best_distinct;
    res_ok      = s2_use && s2_full1;
  end

  // Write ports: clearing pass or count update
  always_comb begin
    if (sweeping) begin
      ins_we    = 1'b1;
      ins_waddr = sweep_cnt;
      ins_wdata = '0;
      rem_we    = 1'b1;
      rem_waddr = sweep_cnt;
      rem_wdata = '0;
    end else begin
      ins_we    = do_inc;
      ins_waddr = s2_id;
      ins_wdata = {epoch, ins_id_c + CB'(1)};
      rem_we    = do_dec;
      rem_waddr = s2_old;
      rem_wdata = {epoch, rem_old_c + CB'(1)};
    end
  end

  // Hold the forwarding record while the pipeline stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      fi_valid <= 1'b0;
      fr_valid <= 1'b0;
    end else if (adv) begin
      fi_valid <= ins_we;
      fr_valid <= rem_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fi_addr <= ins_waddr;
      fi_data <= ins_wdata;
      fr_addr <= rem_waddr;
      fr_data <= rem_wdata;
    end
  end

  // Epoch and clearing pass
  assign bump = (adv && s2_valid && s2_last) || (cfg_we && !sweeping);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping  <= 1'b1;
      sweep_cnt <= '0;
      epoch     <= EPOCH_FIRST;
    end else if (sweeping) begin
      sweep_cnt <= sweep_cnt + ID_BITS'(1);
      if (sweep_cnt == {ID_BITS{1'b1}}) begin
        sweeping <= 1'b0;
        epoch    <= EPOCH_FIRST;
      end
    end else if (bump) begin
      if (epoch == EPOCH_LAST) begin
        sweeping  <= 1'b1;
        sweep_cnt <= '0;
      end else begin
        epoch <= epoch + EPOCH_BITS'(1);
      end
    end
  end

  // Window totals
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      distinct_now  <= '0;
      best_distinct <= '0;
    end else if (adv && s2_valid) begin
      if (s2_last) begin
        distinct_now  <= '0;
        best_distinct <= '0;
      end else begin
        distinct_now  <= dist_new;
        best_distinct <= best_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && s2_valid && s2_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && s2_last) begin
      m_tdata <= DATA_PAD_BITS'(res_ok ? OUT_BITS'(best_new) : OUT_BITS'(0));
      m_tuser <= !res_ok;
    end
  end

  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !s_tready)
    else $error("word taken during clearing pass");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    !sweeping |-> (epoch != '0))
    else $error("epoch matches cleared entries");

  a_stall_keeps_item: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !adv) |=> s2_valid)
    else $error("stalled item dropped");

  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    int'(best_distinct) <= WINDOW_MAX)
    else $error("best count out of range");

endmodule

FILE: tb/tb_sliding_window_distinct_max.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_distinct_max: predicts distinct maxima per sequence.
module tb_sliding_window_distinct_max;
  import swdm_pkg::*;

  typedef struct {
    logic [7:0] id;
    logic       last;
  } id_word_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] max_distinct;
    logic                no_full_window;
  } distinct_result_t;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [WL_BITS-1:0]       cfg_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = '0;   // item_id
  logic                     s_tlast = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [DATA_PAD_BITS-1:0] m_tdata;        // max_distinct, zero fill
  logic [0:0]               m_tuser;        // no_full_window

  id_word_t         id_words[$];
  distinct_result_t distinct_maxima[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      mismatches = 0;

  // Mirror of the window tracking state.
  logic [WL_BITS-1:0] win_len;
  int unsigned        id_count[256];
  logic [7:0]         id_ring[256];
  int unsigned        ring_pos;
  int unsigned        fill;
  int unsigned        distinct_now;
  int unsigned        best_distinct;

  sliding_window_distinct_max dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_window();
    foreach (id_count[i]) id_count[i] = 0;
    ring_pos      = 0;
    fill          = 0;
    distinct_now  = 0;
    best_distinct = 0;
  endfunction

  function automatic void load_window_len(logic [WL_BITS-1:0] len);
    win_len = len;
    clear_window();
  endfunction

  // Advance the window by one word; on the last word queue the sequence maximum.
  function automatic void track_id(id_word_t w);
    logic             usable;
    logic [7:0]       gone;
    distinct_result_t res;
    usable = (win_len != 0) && (win_len <= WINDOW_MAX_DEF);
    if (usable) begin
      if (fill >= win_len) begin
        gone = id_ring[ring_pos];
        // same id entering and leaving leaves the counts alone
        if (gone != w.id) begin
          if (id_count[w.id] == 0) distinct_now++;
          id_count[w.id]++;
          if (id_count[gone] != 0) id_count[gone]--;
          if (id_count[gone] == 0 && distinct_now != 0) distinct_now--;
        end
      end else begin
        if (id_count[w.id] == 0) distinct_now++;
        id_count[w.id]++;
        fill++;
      end
      id_ring[ring_pos] = w.id;
      ring_pos = (ring_pos + 1 >= win_len) ? 0 : ring_pos + 1;
      if (fill >= win_len && distinct_now > best_distinct) best_distinct = distinct_now;
    end
    if (w.last) begin
      if (usable && fill >= win_len) begin
        res.max_distinct   = best_distinct[OUT_BITS-1:0];
        res.no_full_window = 1'b0;
      end else begin
        res.max_distinct   = '0;
        res.no_full_window = 1'b1;
      end
      distinct_maxima.push_back(res);
      clear_window();
    end
  endfunction

  // Word source: hold a word until taken, idle at random between words.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_id(id_words.pop_front());
      if (!s_tvalid || s_tready) begin
        if (id_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= id_words[0].id;
          s_tlast  <= id_words[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result sink: check each word against the oldest expected maximum.
  always @(posedge clk) begin
    distinct_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (distinct_maxima.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
        end else begin
          want = distinct_maxima.pop_front();
          if (m_tdata !== DATA_PAD_BITS'(want.max_distinct)) begin
            mismatches++;
            $display("%0t: max_distinct mismatch: expected %0d, actual %0d",
                     $time, want.max_distinct, m_tdata);
          end
          if (m_tuser[0] !== want.no_full_window) begin
            mismatches++;
            $display("%0t: no_full_window mismatch: expected %b, actual %b",
                     $time, want.no_full_window, m_tuser[0]);
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    while (id_words.size() != 0 || s_tvalid || distinct_maxima.size() != 0)
      @(posedge clk);
    // let words that produce no result clear the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic write_window(input logic [WL_BITS-1:0] len);
    drain();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    load_window_len(len);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      IDLE_BOTH: begin send_idle_pct = 11; recv_stall_pct = 11; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic put(input logic [7:0] id, input logic last);
    id_words.push_back('{id: id, last: last});
  endtask

  task automatic queue_sequence(input int unsigned len, input int unsigned span,
                                input logic closed);
    for (int unsigned i = 0; i < len; i++)
      put(8'($urandom_range(0, span)), closed && (i == len - 1));
  endtask

  task automatic run_phase(input int unsigned len_cfg, input idle_mode_t mode,
                           input int unsigned budget);
    int unsigned pushed;
    int unsigned len;
    int unsigned span;
    write_window(WL_BITS'(len_cfg));
    set_idling(mode);
    pushed = 0;
    @(negedge clk);
    while (pushed < budget) begin
      case ($urandom_range(3))
        0: span = 1;
        1: span = 3;
        2: span = 15;
        default: span = 255;
      endcase
      if (len_cfg == 0 || len_cfg > WINDOW_MAX_DEF) len = $urandom_range(1, 6);
      else if ($urandom_range(99) < 15) len = $urandom_range(1, len_cfg);
      else len = $urandom_range(len_cfg, 3 * len_cfg + 4);
      queue_sequence(len, span, 1'b1);
      pushed += len;
    end
    // sometimes leave a sequence open for the next register write to cut off
    if ($urandom_range(3) == 0) queue_sequence($urandom_range(1, 8), 255, 1'b0);
  endtask

  // Full window of 256 distinct ids, a few more words, then a short sequence.
  task automatic run_full_window(input idle_mode_t mode);
    logic [7:0]  perm[256];
    logic [7:0]  tmp;
    int unsigned j;
    write_window(WL_BITS'(WINDOW_MAX_DEF));
    set_idling(mode);
    foreach (perm[i]) perm[i] = 8'(i);
    for (int i = 255; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    @(negedge clk);
    foreach (perm[i]) put(perm[i], 1'b0);
    queue_sequence(4, 255, 1'b1);
    queue_sequence(8, 255, 1'b1);
  endtask

  initial begin
    win_len = WL_BITS'(1);
    foreach (id_ring[i]) id_ring[i] = '0;
    clear_window();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: window of one after reset
    set_idling(IDLE_NONE);
    @(negedge clk);
    put(8'd0, 1'b1);
    put(8'd255, 1'b0); put(8'd255, 1'b1);
    // zero window ignores words
    write_window(WL_BITS'(0));
    @(negedge clk);
    put(8'h5A, 1'b0); put(8'hA5, 1'b1);
    // sequence shorter than, then equal to, the window
    write_window(WL_BITS'(3));
    @(negedge clk);
    put(8'd1, 1'b0); put(8'd2, 1'b1);
    put(8'd1, 1'b0); put(8'd2, 1'b0); put(8'd3, 1'b1);
    // same id enters as it leaves
    write_window(WL_BITS'(2));
    @(negedge clk);
    put(8'd7, 1'b0); put(8'd9, 1'b0); put(8'd7, 1'b0); put(8'd9, 1'b0); put(8'd7, 1'b1);
    // window above the maximum
    write_window(WL_BITS'(257));
    @(negedge clk);
    put(8'd4, 1'b0); put(8'd4, 1'b1);
    // register write drops an open sequence
    write_window(WL_BITS'(4));
    @(negedge clk);
    put(8'd10, 1'b0); put(8'd11, 1'b0); put(8'd12, 1'b0);
    write_window(WL_BITS'(4));
    @(negedge clk);
    put(8'd1, 1'b0); put(8'd1, 1'b0); put(8'd1, 1'b0); put(8'd1, 1'b0); put(8'd2, 1'b1);

    run_phase(5, IDLE_SEND, 20);
    run_phase(16, IDLE_RECV, 20);
    run_phase(1, IDLE_BOTH, 15);
    run_phase(511, IDLE_NONE, 8);
    run_phase(2, IDLE_SEND, 15);
    run_phase(40, IDLE_BOTH, 20);
    run_full_window(IDLE_RECV);
    run_phase(9, IDLE_NONE, 15);
    run_phase(0, IDLE_BOTH, 8);
    run_phase(3, IDLE_RECV, 15);
    run_phase(1, IDLE_NONE, 10);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("sliding_window_distinct_max verification clean");
    end else begin
      $display("sliding_window_distinct_max verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sliding_window_distinct_max verification failed");
    $finish;
  end

endmodule
